// ----- sv/bss_pkg.sv -----
package bss_pkg;

  localparam int unsigned SlotCountDefault = 256;
  localparam int unsigned SlotW            = 8;
  localparam int unsigned ValueW           = 64;
  localparam int unsigned SlotSpan         = 256;  // slots reachable by an 8-bit index
  localparam int unsigned WordW            = 16;   // bitmap word for the two-level search

  localparam logic [ValueW-1:0] EmptyMark = {1'b1, {(ValueW-1){1'b0}}};

  typedef enum logic [1:0] {
    CmdPush = 2'd0,
    CmdPeek = 2'd1,
    CmdPop  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  typedef struct packed {
    logic [1:0]               command;
    logic [SlotW-1:0]         slot;
    logic signed [ValueW-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [SlotW-1:0]         result_slot;
    logic signed [ValueW-1:0] result_value;
    logic                     hit;
    logic                     full_res;
  } out_res_t;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] idx;
  } find_t;

endpackage

// ----- sv/bss_free_find.sv -----
module bss_free_find #(
  parameter int unsigned SlotLimit = bss_pkg::SlotSpan
) (
  input  logic [SlotLimit-1:0] used_i,
  output bss_pkg::find_t       find_o
);

  localparam int unsigned WordW    = bss_pkg::WordW;
  localparam int unsigned NumWords = (SlotLimit + WordW - 1) / WordW;

  logic [NumWords*WordW-1:0] avail;
  logic [NumWords-1:0]       word_any;
  logic [3:0]                w_sel;
  logic [WordW-1:0]          sel_word;
  logic [3:0]                b_sel;

  // free slots, slot zero and the padding above the store never offered
  always_comb begin
    avail                 = '0;
    avail[SlotLimit-1:0]  = ~used_i;
    avail[0]              = 1'b0;
  end

  always_comb begin
    for (int w = 0; w < NumWords; w++) begin
      word_any[w] = |avail[w*WordW +: WordW];
    end
  end

  // first level: lowest word holding a free slot
  always_comb begin
    w_sel = '0;
    for (int w = NumWords - 1; w >= 0; w--) begin
      if (word_any[w]) begin
        w_sel = 4'(w);
      end
    end
  end

  assign sel_word = avail[w_sel*WordW +: WordW];

  // second level: lowest free bit inside that word
  always_comb begin
    b_sel = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (sel_word[b]) begin
        b_sel = 4'(b);
      end
    end
  end

  assign find_o.found = |word_any;
  assign find_o.idx   = {w_sel, b_sel};

endmodule

// ----- sv/bitmap_slot_store.sv -----
// slot store: one request in, one result out
// the request is registered as it is taken; the result register is written as the execute state
// ends, which an output stall can hold off; no new request is taken until then, so the value
//   memory read and the read-modify-write of memory and occupancy bitmap finish first
// reset: bitmap flip-flops clear at once, every slot free; no clearing pass,
//   the value memory is left as is and is only read for occupied slots
module bitmap_slot_store #(
  parameter int unsigned SlotCount = bss_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bss_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bss_pkg::out_res_t out_res_o
);

  // only slots an 8-bit index can name are ever stored
  localparam int unsigned SlotLimit =
    (SlotCount < bss_pkg::SlotSpan) ? SlotCount : bss_pkg::SlotSpan;
  localparam int unsigned AddrW = $clog2(SlotLimit);

  bss_pkg::state_e   state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [SlotLimit-1:0] used_q, used_d;

  bss_pkg::in_req_t  req_q;
  bss_pkg::out_res_t res_q, res_d;

  // value memory, synchronous read
  logic [bss_pkg::ValueW-1:0] mem_q [SlotLimit];
  logic [bss_pkg::ValueW-1:0] rdata_q;
  logic                       mem_re;
  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;

  bss_pkg::find_t find;

  logic in_accept;
  logic exec_go;
  logic in_range_in;
  logic in_range;
  logic slot_hit;

  assign in_stall_o  = (state_q != bss_pkg::StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  // the result register must be free, or drain this cycle, before we finish
  assign exec_go = (state_q == bss_pkg::StExec) && (!out_valid_q || !out_stall_i);

  assign in_range_in = {1'b0, in_req_i.slot} < 9'(SlotLimit);
  assign in_range    = {1'b0, req_q.slot} < 9'(SlotLimit);
  assign slot_hit    = in_range && used_q[req_q.slot[AddrW-1:0]];

  // read the named slot as the request comes in
  assign mem_re = in_accept && in_range_in;

  bss_free_find #(
    .SlotLimit (SlotLimit)
  ) u_free_find (
    .used_i (used_q),
    .find_o (find)
  );

  // execute: one read-modify-write of bitmap and memory, result into register
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = find.idx[AddrW-1:0];
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      bss_pkg::StIdle: begin
        if (in_accept) begin
          state_d = bss_pkg::StExec;
        end
      end
      bss_pkg::StExec: begin
        if (exec_go) begin
          state_d     = bss_pkg::StIdle;
          out_valid_d = 1'b1;
          res_d       = '0;
          unique case (bss_pkg::cmd_e'(req_q.command)) inside
            bss_pkg::CmdPush: begin
              res_d.result_value = req_q.value;
              if (find.found) begin
                // lowest free slot taken
                mem_we                           = 1'b1;
                used_d[find.idx[AddrW-1:0]]      = 1'b1;
                res_d.result_slot                = find.idx;
                res_d.hit                        = 1'b1;
              end else begin
                // store full, value dropped
                res_d.full_res = 1'b1;
              end
            end
            bss_pkg::CmdPeek, bss_pkg::CmdPop: begin
              res_d.result_slot  = req_q.slot;
              res_d.result_value = bss_pkg::EmptyMark;
              if (slot_hit) begin
                res_d.result_value = rdata_q;
                res_d.hit          = 1'b1;
                if (bss_pkg::cmd_e'(req_q.command) == bss_pkg::CmdPop) begin
                  used_d[req_q.slot[AddrW-1:0]] = 1'b0;
                end
              end
            end
            default: begin
              // unused command code: all-zero result, nothing changes
              res_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = bss_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bss_pkg::StIdle;
      out_valid_q <= 1'b0;
      used_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
    if (exec_go) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= req_q.value;
    end
    if (mem_re) begin
      rdata_q <= mem_q[in_req_i.slot[AddrW-1:0]];
    end
  end

endmodule

// ----- test/bitmap_slot_store_check.sv -----
module bitmap_slot_store_check #(
  parameter int unsigned SlotCount = bss_pkg::SlotCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  bss_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  bss_pkg::out_res_t out_res_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       outstanding_o,
  output int unsigned       full_count_o
);

  // push only hands out slots that an 8-bit index can name
  localparam int unsigned SearchEnd =
    (SlotCount < bss_pkg::SlotSpan) ? SlotCount : bss_pkg::SlotSpan;

  logic signed [bss_pkg::ValueW-1:0] stored_value [SlotCount];
  bit                                occupied     [SlotCount];
  bss_pkg::out_res_t                 pending_q    [$];
  bss_pkg::out_res_t                 want;
  int unsigned                       mismatches;
  int unsigned                       refused;

  function automatic bss_pkg::out_res_t store_apply(bss_pkg::in_req_t req);
    bss_pkg::out_res_t res;
    bit                found;
    int unsigned       idx;
    res   = '0;
    found = 1'b0;
    idx   = 0;
    case (req.command) inside
      bss_pkg::CmdPush: begin
        res.result_value = req.value;
        for (int unsigned s = 1; s < SearchEnd; s++) begin
          if (!found && !occupied[s]) begin
            found = 1'b1;
            idx   = s;
          end
        end
        if (found) begin
          stored_value[idx] = req.value;
          occupied[idx]     = 1'b1;
          res.result_slot   = idx[bss_pkg::SlotW-1:0];
          res.hit           = 1'b1;
        end else begin
          res.full_res = 1'b1;
          refused++;
        end
      end
      bss_pkg::CmdPeek, bss_pkg::CmdPop: begin
        res.result_slot  = req.slot;
        res.result_value = bss_pkg::EmptyMark;
        if (req.slot < SlotCount && occupied[req.slot]) begin
          res.result_value = stored_value[req.slot];
          res.hit          = 1'b1;
          if (req.command == bss_pkg::CmdPop) begin
            occupied[req.slot] = 1'b0;
          end
        end
      end
      default: ;  // unused command: all fields zero, store untouched
    endcase
    return res;
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (occupied[i]) occupied[i] = 1'b0;
      pending_q.delete();
      mismatches = 0;
      refused    = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
      full_count_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t unexpected result: slot %0d value %h hit %b full %b", $time,
                     out_res_i.result_slot, out_res_i.result_value, out_res_i.hit,
                     out_res_i.full_res);
          end
        end else begin
          want = pending_q.pop_front();
          if (out_res_i.result_slot !== want.result_slot ||
              out_res_i.result_value !== want.result_value ||
              out_res_i.hit !== want.hit || out_res_i.full_res !== want.full_res) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t result mismatch: slot %0d/%0d value %h/%h hit %b/%b full %b/%b",
                       $time, want.result_slot, out_res_i.result_slot, want.result_value,
                       out_res_i.result_value, want.hit, out_res_i.hit, want.full_res,
                       out_res_i.full_res);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_q.push_back(store_apply(in_req_i));
      end
      mismatch_count_o <= mismatches;
      outstanding_o    <= pending_q.size();
      full_count_o     <= refused;
    end
  end

endmodule

// ----- test/bitmap_slot_store_test.sv -----
module bitmap_slot_store_test;

  // command code the block does not define; it must answer with an all-zero result
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned HoldCycles  = 90;    // long output hold that fills the block
  localparam int unsigned QuietLimit  = 2000;  // cycles without any handshake
  localparam int unsigned DrainCycles = 8;     // extra cycles after the last result

  localparam logic signed [bss_pkg::ValueW-1:0] ValueMax =
    {1'b0, {(bss_pkg::ValueW-1){1'b1}}};
  localparam logic signed [bss_pkg::ValueW-1:0] ValueMin = bss_pkg::EmptyMark;

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  bss_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bss_pkg::out_res_t out_res;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned refused;

  // stimulus-side view of which slots hold a value, only used to aim peek and pop
  bit          busy [bss_pkg::SlotSpan];
  int unsigned n_push, n_peek, n_pop, n_unused;
  int unsigned quiet;
  bit          calm;       // last part of the run: no idling on either side
  bit          hold_req;   // asks the output side for one long hold
  bit          hold_done;  // the output side has finished that hold

  bitmap_slot_store dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  bitmap_slot_store_check store_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_res_i        (out_res),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .full_count_o     (refused)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one request after an optional idle gap and wait until it is taken;
  // valid is lowered only when a gap follows, so it never toggles within one step
  task automatic offer(input bss_pkg::in_req_t req, input int unsigned gap);
    bit placed;
    placed = 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    // keep the occupancy view in step with what the block has taken
    case (req.command)
      bss_pkg::CmdPush: begin
        n_push++;
        for (int unsigned s = 1; s < bss_pkg::SlotSpan; s++) begin
          if (!placed && !busy[s]) begin
            busy[s] = 1'b1;
            placed  = 1'b1;
          end
        end
      end
      bss_pkg::CmdPeek: n_peek++;
      bss_pkg::CmdPop: begin
        n_pop++;
        busy[req.slot] = 1'b0;
      end
      default: n_unused++;
    endcase
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [bss_pkg::SlotW-1:0] slot,
                          input logic signed [bss_pkg::ValueW-1:0] value);
    bss_pkg::in_req_t req;
    req.command = cmd;
    req.slot    = slot;
    req.value   = value;
    offer(req, 0);
  endtask

  // random requests with a given push and pop share in percent; most peek and pop
  // requests aim at an occupied slot so that hits and frees happen often
  task automatic run_random(input int unsigned count, input int unsigned push_pct,
                            input int unsigned pop_pct);
    bss_pkg::in_req_t req;
    int unsigned      roll;
    int unsigned      start;
    int unsigned      gap;
    bit               aimed;
    repeat (count) begin
      req.slot = bss_pkg::SlotW'($urandom);
      case ($urandom_range(9))
        0:       req.value = ValueMax;
        1:       req.value = ValueMin;
        2:       req.value = '0;
        3:       req.value = '1;
        default: req.value = {$urandom, $urandom};
      endcase
      roll = $urandom_range(99);
      if (roll < 2) begin
        req.command = CmdUnused;
      end else if (roll < push_pct) begin
        req.command = bss_pkg::CmdPush;
      end else if (roll < push_pct + pop_pct) begin
        req.command = bss_pkg::CmdPop;
      end else begin
        req.command = bss_pkg::CmdPeek;
      end
      if ((req.command == bss_pkg::CmdPeek || req.command == bss_pkg::CmdPop) &&
          $urandom_range(9) < 8) begin
        aimed = 1'b0;
        start = $urandom_range(bss_pkg::SlotSpan - 1);
        for (int unsigned k = 0; k < bss_pkg::SlotSpan; k++) begin
          if (!aimed && busy[(start + k) % bss_pkg::SlotSpan]) begin
            req.slot = bss_pkg::SlotW'((start + k) % bss_pkg::SlotSpan);
            aimed    = 1'b1;
          end
        end
      end
      // input idling in bursts, suppressed while the output hold is meant to fill the block
      gap = 0;
      if (!calm && !(hold_req && !hold_done) && $urandom_range(7) == 0) begin
        gap = $urandom_range(1, 18);
      end
      offer(req, gap);
    end
  endtask

  // output side: random stall bursts, one long hold on request, none in the calm part
  initial begin
    int unsigned s;
    int unsigned r;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
        s = 0;
      end else if (calm || $urandom_range(3) != 0) begin
        s = 0;
      end else begin
        s = $urandom_range(1, 18);
      end
      if (s > 0) begin
        out_stall <= 1'b1;
        repeat (s) @(posedge clk);
      end
      out_stall <= 1'b0;
      r = calm ? 1 : $urandom_range(1, 24);
      repeat (r) @(posedge clk);
    end
  end

  // watchdog: too long without any request or result taken ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QuietLimit) begin
        $display("bitmap_slot_store_test failed");
        $finish;
      end
    end
  end

  initial begin
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: misses on an empty store, value extremes, reuse of the
    // lowest freed slot, slot zero, the top slot index and the unused command
    send_cmd(bss_pkg::CmdPeek, 8'd0, '0);
    send_cmd(bss_pkg::CmdPop, 8'd5, ValueMax);
    send_cmd(bss_pkg::CmdPush, 8'd0, ValueMax);
    send_cmd(bss_pkg::CmdPush, 8'd0, ValueMin);
    send_cmd(bss_pkg::CmdPush, 8'd7, '0);
    send_cmd(bss_pkg::CmdPush, 8'hff, '1);
    send_cmd(bss_pkg::CmdPeek, 8'd1, '0);
    send_cmd(bss_pkg::CmdPeek, 8'd2, '1);
    send_cmd(bss_pkg::CmdPeek, 8'd0, ValueMin);
    send_cmd(bss_pkg::CmdPop, 8'd2, '0);
    send_cmd(bss_pkg::CmdPop, 8'd2, '0);
    send_cmd(bss_pkg::CmdPush, 8'd0, 64'sh5555_5555_5555_5555);
    send_cmd(bss_pkg::CmdPeek, 8'd2, '0);
    send_cmd(bss_pkg::CmdPeek, 8'hff, '0);
    send_cmd(bss_pkg::CmdPop, 8'hff, '1);
    send_cmd(CmdUnused, 8'ha5, 64'sh1234_5678_9abc_def0);
    send_cmd(bss_pkg::CmdPush, 8'haa, 64'sh2aaa_aaaa_aaaa_aaaa);
    send_cmd(bss_pkg::CmdPop, 8'd1, '0);
    send_cmd(bss_pkg::CmdPop, 8'd3, '0);
    send_cmd(bss_pkg::CmdPop, 8'd4, '0);
    send_cmd(bss_pkg::CmdPop, 8'd2, '0);
    send_cmd(bss_pkg::CmdPeek, 8'd5, '0);

    // fill the store well past full; partway in, hold the output so the block backs up
    run_random(200, 78, 10);
    hold_req = 1'b1;
    run_random(500, 78, 10);

    // let every outstanding result come back before the drain phase
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);

    run_random(600, 15, 65);
    run_random(380, 50, 30);
    calm = 1'b1;
    run_random(250, 50, 30);

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests: %0d push, %0d peek, %0d pop, %0d unused command",
             n_push + n_peek + n_pop + n_unused, n_push, n_peek, n_pop, n_unused);
    $display("%0d pushes refused on a full store, one long output hold, one full drain",
             refused);
    if (mismatches == 0 && outstanding == 0) begin
      $display("bitmap_slot_store_test passed");
    end else begin
      $display("bitmap_slot_store_test failed");
    end
    $finish;
  end

endmodule
